// ===== hdl/cpr_pkg.sv =====
`timescale 1ns / 1ps
package cpr_pkg;

  localparam int ActionW   = 2;
  localparam int PointIdxW = 6;
  localparam int CoordIdxW = 3;
  localparam int CoordW    = 24;
  localparam int CountW    = 7;
  localparam int DimsW     = 4;
  localparam int SqW       = 2 * CoordW;

  localparam logic [DimsW-1:0] DimsReset = 4'd1;

  typedef enum logic [ActionW-1:0] {
    ActLoad = 2'd0,
    ActFind = 2'd1,
    ActRead = 2'd2
  } action_e;

  // Which kind of result the output register takes.
  typedef enum logic [1:0] {
    ResPlain = 2'd0,
    ResPair  = 2'd1,
    ResRead  = 2'd2
  } res_e;

  typedef struct packed {
    logic load_write;
    logic read_issue;
    logic find_short;
    logic scan_issue;
    logic pair_first;
    logic pair_last;
    logic coord_zero;
    logic best_init;
    logic copy_issue;
    logic finish_find;
    logic out_load;
    res_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic pipe_busy;
  } sts_t;

endpackage

// ===== hdl/cpr_ram.sv =====
`timescale 1ns / 1ps
module cpr_ram #(
  parameter int Width = 24,
  parameter int Depth = 512,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AddrW-1:0] raddr_a_i,
  output logic [Width-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hdl/cpr_dp.sv =====
`timescale 1ns / 1ps
module cpr_dp
  import cpr_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS   = 8,
  localparam int PtW  = $clog2(MAX_POINTS),
  localparam int CntW = $clog2(MAX_POINTS + 1),
  localparam int KW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  input  logic [PtW-1:0]              pt_a_i,
  input  logic [PtW-1:0]              pt_b_i,
  input  logic [KW-1:0]               k_i,
  input  logic [CntW-1:0]             count_i,
  output logic [PtW-1:0]              lo_o,
  output logic [PtW-1:0]              hi_o,
  input  logic [PointIdxW-1:0]        point_index_i,
  input  logic [CoordIdxW-1:0]        coordinate_index_i,
  input  logic signed [CoordW-1:0]    coordinate_value_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [PointIdxW-1:0]        first_index_o,
  output logic [PointIdxW-1:0]        second_index_o,
  output logic                        pair_removed_o,
  output logic [CountW-1:0]           remaining_count_o,
  output logic signed [CoordW-1:0]    read_value_o,
  output logic                        out_of_range_o
);

  localparam int Depth = MAX_POINTS * MAX_DIMS;
  localparam int AddrW = $clog2(Depth);
  localparam int DiffW = CoordW + 1;
  localparam int DistW = SqW + $clog2(MAX_DIMS);

  typedef struct packed {
    logic           first;
    logic           last;
    logic           init;
    logic [PtW-1:0] i;
    logic [PtW-1:0] j;
  } tag_t;

  function automatic logic [AddrW-1:0] word_addr(input logic [PtW-1:0] pt,
                                                 input logic [KW-1:0]  k);
    word_addr = AddrW'(pt) * AddrW'(MAX_DIMS) + AddrW'(k);
  endfunction

  logic                    we;
  logic [AddrW-1:0]        waddr;
  logic [CoordW-1:0]       wdata;
  logic                    re_a;
  logic [AddrW-1:0]        raddr_a;
  logic [CoordW-1:0]       rdata_a;
  logic [AddrW-1:0]        raddr_b;
  logic [CoordW-1:0]       rdata_b;

  logic [PtW-1:0]          in_pt;
  logic [KW-1:0]           in_k;
  logic                    load_ok;
  logic                    rd_oor;
  logic                    rd_zero;

  logic                    cp_wr_q;
  logic [AddrW-1:0]        cp_addr_q;
  logic                    rd_oor_q;
  logic                    rd_zero_q;

  logic                    s1_valid_q, s2_valid_q, s3_valid_q, done_q;
  logic                    s1_zero_q;
  tag_t                    s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q;
  logic signed [DiffW-1:0] diff_q;
  logic signed [2*DiffW-1:0] prod;
  logic [SqW-1:0]          sq_q;
  logic [DistW-1:0]        acc_q;
  logic [DistW-1:0]        best_q;
  logic [PtW-1:0]          lo_q;
  logic [PtW-1:0]          hi_q;
  logic [CntW-1:0]         points_left_q;

  logic                    out_valid_q;
  logic [PointIdxW-1:0]    first_q, second_q;
  logic                    removed_q;
  logic [CountW-1:0]       remaining_q;
  logic [CoordW-1:0]       read_value_q;
  logic                    oor_q;

  // Store access: loads and reads use the item fields, the scan and the
  // removal copy use the indices from the controller.
  assign in_pt   = PtW'(point_index_i);
  assign in_k    = KW'(coordinate_index_i);
  assign load_ok = (int'(point_index_i) < MAX_POINTS) && (int'(coordinate_index_i) < MAX_DIMS);
  assign rd_oor  = int'(point_index_i) >= int'(points_left_q);
  assign rd_zero = !rd_oor && (int'(coordinate_index_i) >= MAX_DIMS);

  assign we      = (cmd_i.load_write && load_ok) || cp_wr_q;
  assign waddr   = cp_wr_q ? cp_addr_q : word_addr(in_pt, in_k);
  assign wdata   = cp_wr_q ? rdata_a : coordinate_value_i;
  assign re_a    = cmd_i.scan_issue || cmd_i.copy_issue ||
                   (cmd_i.read_issue && !rd_oor && !rd_zero);
  assign raddr_a = cmd_i.read_issue ? word_addr(in_pt, in_k) : word_addr(pt_a_i, k_i);
  assign raddr_b = word_addr(pt_b_i, k_i);

  cpr_ram #(
    .Width(CoordW),
    .Depth(Depth)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .re_a_i   (re_a),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .re_b_i   (cmd_i.scan_issue),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  assign prod = diff_q * diff_q;

  // Control side of the distance pipeline, the copy write and the search state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      done_q        <= 1'b0;
      cp_wr_q       <= 1'b0;
      rd_oor_q      <= 1'b0;
      rd_zero_q     <= 1'b0;
      best_q        <= '0;
      lo_q          <= '0;
      hi_q          <= PtW'(1);
      points_left_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.scan_issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      done_q     <= s3_valid_q && s3_tag_q.last;
      cp_wr_q    <= cmd_i.copy_issue;
      if (cmd_i.read_issue) begin
        rd_oor_q  <= rd_oor;
        rd_zero_q <= rd_zero;
      end
      // The first pair seeds the search; later pairs win only when strictly closer.
      if (done_q && (s4_tag_q.init || (acc_q < best_q))) begin
        best_q <= acc_q;
        lo_q   <= s4_tag_q.i;
        hi_q   <= s4_tag_q.j;
      end
      if (cmd_i.find_short) begin
        points_left_q <= count_i;
      end else if (cmd_i.finish_find) begin
        points_left_q <= count_i - CntW'(2);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cp_addr_q <= word_addr(pt_b_i, k_i);
    s1_zero_q <= cmd_i.coord_zero;
    s1_tag_q  <= '{first: cmd_i.pair_first, last: cmd_i.pair_last,
                   init: cmd_i.best_init, i: pt_a_i, j: pt_b_i};
    s2_tag_q  <= s1_tag_q;
    s3_tag_q  <= s2_tag_q;
    if (s1_zero_q) begin
      diff_q <= '0;
    end else begin
      diff_q <= $signed({rdata_a[CoordW-1], rdata_a}) - $signed({rdata_b[CoordW-1], rdata_b});
    end
    sq_q <= prod[SqW-1:0];
    if (s3_valid_q) begin
      acc_q    <= (s3_tag_q.first ? '0 : acc_q) + DistW'(sq_q);
      s4_tag_q <= s3_tag_q;
    end
    if (cmd_i.out_load) begin
      first_q      <= '0;
      second_q     <= '0;
      removed_q    <= 1'b0;
      remaining_q  <= CountW'(points_left_q);
      read_value_q <= '0;
      oor_q        <= 1'b0;
      case (cmd_i.res_sel)
        ResPair: begin
          first_q   <= PointIdxW'(lo_q);
          second_q  <= PointIdxW'(hi_q);
          removed_q <= 1'b1;
        end
        ResRead: begin
          read_value_q <= (rd_oor_q || rd_zero_q) ? '0 : rdata_a;
          oor_q        <= rd_oor_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.pipe_busy = s1_valid_q || s2_valid_q || s3_valid_q || done_q;
  assign lo_o            = lo_q;
  assign hi_o            = hi_q;

  assign out_valid_o       = out_valid_q;
  assign first_index_o     = first_q;
  assign second_index_o    = second_q;
  assign pair_removed_o    = removed_q;
  assign remaining_count_o = remaining_q;
  assign read_value_o      = read_value_q;
  assign out_of_range_o    = oor_q;

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cp_wr_q && cmd_i.load_write))
    else $error("copy write and load write in the same cycle");

  a_finish_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish_find |-> !(s1_valid_q || s2_valid_q || s3_valid_q || done_q))
    else $error("removal finished while distances were still in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(points_left_q) <= MAX_POINTS)
    else $error("remaining point count beyond the store");

endmodule

// ===== hdl/cpr_ctrl.sv =====
`timescale 1ns / 1ps
module cpr_ctrl
  import cpr_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS   = 8,
  localparam int PtW  = $clog2(MAX_POINTS),
  localparam int CntW = $clog2(MAX_POINTS + 1),
  localparam int KW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [DimsW-1:0]   cfg_dimensions_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [CountW-1:0]  point_count_i,
  input  sts_t               sts_i,
  input  logic [PtW-1:0]     lo_i,
  input  logic [PtW-1:0]     hi_i,
  output cmd_t               cmd_o,
  output logic [PtW-1:0]     pt_a_o,
  output logic [PtW-1:0]     pt_b_o,
  output logic [KW-1:0]      k_o,
  output logic [CntW-1:0]    count_o
);

  localparam int DeW = DimsW + 1;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StRead  = 7'b0000010,
    StScan  = 7'b0000100,
    StDrain = 7'b0001000,
    StCopy  = 7'b0010000,
    StCfin  = 7'b0100000,
    StResp  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  res_e             res_q, res_d;
  logic [PtW-1:0]   i_q, i_d, j_q, j_d, p_q, p_d;
  logic [KW-1:0]    k_q, k_d;
  logic [CntW-1:0]  n_q, n_d, n_in;
  logic [DimsW-1:0] dims_q;
  logic [DeW-1:0]   dims_eff;
  logic             accept;
  logic             k_last_scan, j_last, i_last;
  logic             k_last_copy, copy_done;
  logic [PtW-1:0]   src_pt;

  assign n_in     = (int'(point_count_i) > MAX_POINTS) ? CntW'(MAX_POINTS)
                                                       : CntW'(point_count_i);
  assign dims_eff = (int'(dims_q) > MAX_DIMS) ? DeW'(MAX_DIMS) : {1'b0, dims_q};

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // With no dimensions in use every pair is scanned as a single coordinate of zero distance.
  assign k_last_scan = (dims_eff == '0) || (int'(k_q) == int'(dims_eff) - 1);
  assign j_last      = int'(j_q) == int'(n_q) - 1;
  assign i_last      = int'(i_q) == int'(n_q) - 2;
  assign k_last_copy = int'(k_q) == MAX_DIMS - 1;
  assign copy_done   = k_last_copy && (int'(p_q) == int'(n_q) - 2);

  // Slot p takes the next survivor: one slot up before the upper point, two
  // slots up after it, and the last slot when p is slot n-2.
  assign src_pt = ((int'(p_q) + 1 < int'(hi_i)) || (int'(p_q) == int'(n_q) - 2))
                  ? p_q + 1'b1 : p_q + PtW'(2);

  assign pt_b_o  = (state_q == StCopy) ? p_q : j_q;
  assign k_o     = k_q;
  assign count_o = (state_q == StIdle) ? n_in : n_q;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    i_d     = i_q;
    j_d     = j_q;
    p_d     = p_q;
    k_d     = k_q;
    n_d     = n_q;
    cmd_o   = '0;
    pt_a_o  = i_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (action_e'(action_i))
            ActFind: begin
              n_d = n_in;
              if (int'(n_in) < 2) begin
                cmd_o.find_short = 1'b1;
                res_d            = ResPlain;
                state_d          = StResp;
              end else begin
                i_d     = '0;
                j_d     = PtW'(1);
                k_d     = '0;
                state_d = StScan;
              end
            end
            ActRead: begin
              cmd_o.read_issue = 1'b1;
              state_d          = StRead;
            end
            ActLoad: begin
              cmd_o.load_write = 1'b1;
              if (sts_i.out_free) begin
                cmd_o.out_load = 1'b1;
                cmd_o.res_sel  = ResPlain;
              end else begin
                res_d   = ResPlain;
                state_d = StResp;
              end
            end
            default: begin
              if (sts_i.out_free) begin
                cmd_o.out_load = 1'b1;
                cmd_o.res_sel  = ResPlain;
              end else begin
                res_d   = ResPlain;
                state_d = StResp;
              end
            end
          endcase
        end
      end
      StRead: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = ResRead;
          state_d        = StIdle;
        end else begin
          res_d   = ResRead;
          state_d = StResp;
        end
      end
      StScan: begin
        cmd_o.scan_issue = 1'b1;
        cmd_o.pair_first = (k_q == '0);
        cmd_o.pair_last  = k_last_scan;
        cmd_o.coord_zero = (dims_eff == '0);
        cmd_o.best_init  = (i_q == '0) && (j_q == PtW'(1));
        if (k_last_scan) begin
          k_d = '0;
          if (j_last) begin
            if (i_last) begin
              state_d = StDrain;
            end else begin
              i_d = i_q + 1'b1;
              j_d = i_q + PtW'(2);
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StDrain: begin
        if (!sts_i.pipe_busy) begin
          p_d     = lo_i;
          k_d     = '0;
          state_d = StCopy;
        end
      end
      StCopy: begin
        cmd_o.copy_issue = 1'b1;
        pt_a_o           = src_pt;
        if (copy_done) begin
          state_d = StCfin;
        end else if (k_last_copy) begin
          k_d = '0;
          p_d = p_q + 1'b1;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StCfin: begin
        cmd_o.finish_find = 1'b1;
        res_d             = ResPair;
        state_d           = StResp;
      end
      StResp: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = res_q;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      res_q   <= ResPlain;
      i_q     <= '0;
      j_q     <= '0;
      p_q     <= '0;
      k_q     <= '0;
      n_q     <= '0;
      dims_q  <= DimsReset;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      i_q     <= i_d;
      j_q     <= j_d;
      p_q     <= p_d;
      k_q     <= k_d;
      n_q     <= n_d;
      if (cfg_valid_i) begin
        dims_q <= cfg_dimensions_i;
      end
    end
  end

  a_scan_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (i_q < j_q) && (int'(j_q) < int'(n_q)))
    else $error("scan pair out of order or beyond the point count");

  a_copy_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCopy) |-> (int'(src_pt) > int'(p_q)) && (int'(src_pt) < int'(n_q)))
    else $error("copy source not above its destination");

  a_pair_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCopy) |-> (lo_i < hi_i))
    else $error("closest pair indices not ordered");

endmodule

// ===== hdl/closest_pair_remove.sv =====
`timescale 1ns / 1ps
// Closest pair finder with removal. Points are loaded one coordinate per beat
// into a store of MAX_POINTS x MAX_DIMS words; a load hands its result
// straight to the output register when that register is free, a read passes
// through a read state first. A find beat walks every pair i<j of the first
// point_count slots through a distance pipeline fed by the two read ports of
// the store, one coordinate pair per cycle, with dimensions capped at
// MAX_DIMS and a single zero-distance coordinate per pair when none are in
// use, and then lets the pipeline drain. The removal then copies the
// survivors down through one read and one write port, all MAX_DIMS words of
// each slot from the lower removed index up to slot n-2, and then finishes
// and presents the result. A find with fewer than two points goes straight
// to its result. A result that finds the output register still full waits
// until it is free. The next beat is taken as soon as the current one has
// finished, even while its result still waits in the output register.
module closest_pair_remove
  import cpr_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int MAX_DIMS   = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [DimsW-1:0]         cfg_dimensions_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ActionW-1:0]       action_i,
  input  logic [PointIdxW-1:0]     point_index_i,
  input  logic [CoordIdxW-1:0]     coordinate_index_i,
  input  logic signed [CoordW-1:0] coordinate_value_i,
  input  logic [CountW-1:0]        point_count_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [PointIdxW-1:0]     first_index_o,
  output logic [PointIdxW-1:0]     second_index_o,
  output logic                     pair_removed_o,
  output logic [CountW-1:0]        remaining_count_o,
  output logic signed [CoordW-1:0] read_value_o,
  output logic                     out_of_range_o
);

  localparam int PtW  = $clog2(MAX_POINTS);
  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int KW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  cmd_t            cmd;
  sts_t            sts;
  logic [PtW-1:0]  pt_a, pt_b, lo, hi;
  logic [KW-1:0]   k;
  logic [CntW-1:0] count;

  // The dimensions register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;

  cpr_ctrl #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_DIMS  (MAX_DIMS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_dimensions_i(cfg_dimensions_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .point_count_i   (point_count_i),
    .sts_i           (sts),
    .lo_i            (lo),
    .hi_i            (hi),
    .cmd_o           (cmd),
    .pt_a_o          (pt_a),
    .pt_b_o          (pt_b),
    .k_o             (k),
    .count_o         (count)
  );

  cpr_dp #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_DIMS  (MAX_DIMS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .pt_a_i            (pt_a),
    .pt_b_i            (pt_b),
    .k_i               (k),
    .count_i           (count),
    .lo_o              (lo),
    .hi_o              (hi),
    .point_index_i     (point_index_i),
    .coordinate_index_i(coordinate_index_i),
    .coordinate_value_i(coordinate_value_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .first_index_o     (first_index_o),
    .second_index_o    (second_index_o),
    .pair_removed_o    (pair_removed_o),
    .remaining_count_o (remaining_count_o),
    .read_value_o      (read_value_o),
    .out_of_range_o    (out_of_range_o)
  );

endmodule
